### rtl/modbus_rtu_slave_bit_register_memory_unit_defines.svh
// Assertion macros for the Modbus RTU slave block.
`ifndef MODBUS_RTU_SLAVE_BIT_REGISTER_MEMORY_UNIT_DEFINES_SVH
`define MODBUS_RTU_SLAVE_BIT_REGISTER_MEMORY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MBSLV_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbslv: same-cycle check failed");
`define MBSLV_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbslv: next-cycle check failed");
`else
`define MBSLV_ASSERT_IMP(label, ante, cons)
`define MBSLV_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/mbslv_pkg.sv
package mbslv_pkg;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_SLAVE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_BASE     = 1'b1;

   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [15:0] AREA_BASE_RESET     = 16'd3000;

   localparam int STORE_DEPTH = 64;
   localparam int STORE_AW    = 6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] MAX_DATA    = 8'd32;
   localparam logic [7:0] MAX_REGS    = 8'd16;
   localparam logic [7:0] COIL_ON     = 8'hFF;
   localparam logic [6:0] FIXED_LEN   = 7'd8;
   localparam logic [6:0] MULTI_EXTRA = 7'd9;
   localparam logic [6:0] COUNT_POS_N = 7'd7;   // byte count present once 7 bytes are in
   localparam logic [STORE_AW-1:0] DATA_POS  = 6'd7;
   localparam logic [STORE_AW-1:0] DATA_POS2 = 6'd8;

   localparam logic [7:0] FC_READ_COILS     = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE  = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_READ_INPUT     = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL     = 8'd5;
   localparam logic [7:0] FC_WRITE_REG      = 8'd6;
   localparam logic [7:0] FC_WRITE_COILS    = 8'd15;
   localparam logic [7:0] FC_WRITE_REGS     = 8'd16;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'd0, b};
      for (int j = 0; j < 8; j++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

### rtl/modbus_rtu_slave_bit_register_memory_unit.sv
// Modbus RTU slave over a MEM_BYTES byte memory. Frame bytes are taken one per cycle while
// receiving; a frame for this station is kept in a 64-byte frame memory and its CRC is run
// as the bytes arrive. On the final byte of a good frame the block stops taking bytes and
// serves the request from the data memory; a read asking for too much data is dropped.
// Codes 5 and 15 read and rewrite the data byte for each bit written, codes 6 and 16 read
// each register from the frame memory and write both bytes; the reply goes out at one
// header byte per cycle, each data byte read before it is sent, then two CRC bytes, each
// byte also waiting for the output register to be free. After reset a clearing pass zeroes
// the data memory before the first byte is taken; configuration writes are taken at any time.
`include "modbus_rtu_slave_bit_register_memory_unit_defines.svh"

module modbus_rtu_slave_bit_register_memory_unit #(
   parameter int MEM_BYTES   = 64,
   parameter int FRAME_BYTES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   input  logic                             req_frame_start,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_last,
   input  logic                             csr_wr_en,
   input  logic [mbslv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbslv_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import mbslv_pkg::*;

   localparam int MAW   = $clog2(MEM_BYTES);
   localparam int LIMIT = (FRAME_BYTES < STORE_DEPTH) ? FRAME_BYTES : STORE_DEPTH;

   typedef enum logic [4:0] {
      S_CLEAR, S_RX,
      S_B_RD, S_B_WR,
      S_R_RD0, S_R_RD1, S_R_WR0, S_R_WR1,
      S_HDR,
      S_BR_RD0, S_BR_LO, S_BR_WAIT, S_BR_EMIT,
      S_RR_RDH, S_RR_EH, S_RR_RDL, S_RR_EL,
      S_CRCL, S_CRCH
   } state_type;

   state_type   state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        disc_ff, disc_in;
   logic [7:0]  hdr_ff [7];
   logic [7:0]  hdr_in [7];
   logic [7:0]  prev_ff, prev_in;
   logic [15:0] crc_run_ff, crc_run_in;
   logic [15:0] crc_d1_ff, crc_d1_in;
   logic [15:0] crc_tx_ff, crc_tx_in;
   logic        in_ff, in_in;
   logic [15:0] rel_ff, rel_in;
   logic [8:0]  idx_ff, idx_in;
   logic [8:0]  ncount_ff, ncount_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [7:0]  lo_ff, lo_in;
   logic [7:0]  hi_ff, hi_in;
   logic        rd_ok_ff, rd_ok_in;
   logic [MAW-1:0] clr_ff, clr_in;
   logic [7:0]  slave_ff, slave_in;
   logic [15:0] base_ff, base_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_tx_byte_ff, rsp_tx_byte_in;
   logic        rsp_last_ff, rsp_last_in;

   // memory ports
   logic                frm_we;
   logic [STORE_AW-1:0] frm_waddr, frm_raddr;
   logic [7:0]          frm_q;
   logic                mem_we;
   logic [MAW-1:0]      mem_waddr, mem_raddr;
   logic [7:0]          mem_wdata, mem_rdata, mem_q;

   logic        req_fire, o_free, emit_req, emit_last, emit_fire;
   logic [7:0]  emit_byte;
   logic [15:0] q_w, addr_w;
   logic [16:0] sum_w;
   logic [13:0] bbyte, rb_lo, rb_hi;
   logic [17:0] ra0, ra1, mraddr_full, chk_full;
   logic [7:0]  bit_m;
   logic        bitval, is_read, is_bits, last_hdr, loop_done;
   logic [15:0] win, rem;
   logic [7:0]  bmask;
   logic [13:0] nb_w;
   logic [15:0] cap16, n16;
   logic [7:0]  cnt_byte;

   // rx path
   logic [6:0]  cnt_eff, cnt_n, len;
   logic        disc_eff, len_ok, start;
   logic [7:0]  b0, fcb, b6;
   logic        in_c;
   logic [15:0] rel_c;

   mbslv_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_frame (
      .clock(clock), .wr_en(frm_we), .wr_addr(frm_waddr), .wr_data(req_rx_byte),
      .rd_addr(frm_raddr), .rd_data(frm_q)
   );

   mbslv_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_data (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
      .rd_addr(mem_raddr), .rd_data(mem_rdata)
   );

   assign req_ready   = (state_ff == S_RX);
   assign req_fire    = req_valid && req_ready;
   assign o_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_last    = rsp_last_ff;

   assign q_w    = {hdr_ff[4], hdr_ff[5]};
   assign addr_w = {hdr_ff[2], hdr_ff[3]};
   assign in_c   = (addr_w >= base_ff);
   assign rel_c  = addr_w - base_ff;

   assign sum_w = {1'b0, rel_ff} + {8'd0, idx_ff};
   assign bbyte = sum_w[16:3];
   assign ra0   = {sum_w, 1'b0};
   assign ra1   = ra0 + 18'd1;
   assign rb_lo = {1'b0, rel_ff[15:3]} + {5'd0, idx_ff};
   assign rb_hi = rb_lo + 14'd1;
   assign bit_m = 8'd1 << sum_w[2:0];
   assign mem_q = rd_ok_ff ? mem_rdata : 8'd0;

   assign is_bits   = (hdr_ff[1] == FC_READ_COILS) || (hdr_ff[1] == FC_READ_DISCRETE);
   assign is_read   = is_bits || (hdr_ff[1] == FC_READ_HOLDING) ||
                      (hdr_ff[1] == FC_READ_INPUT);
   assign last_hdr  = is_read ? (hidx_ff == 3'd2) : (hidx_ff == 3'd5);
   assign loop_done = ((idx_ff + 9'd1) == ncount_ff);
   assign cnt_byte  = is_bits ? ncount_ff[7:0] : {ncount_ff[6:0], 1'b0};

   // read window for unaligned bit reads
   assign win   = {mem_q, lo_ff} >> rel_ff[2:0];
   assign rem   = q_w - {4'd0, idx_ff, 3'd0};
   assign bmask = (rem >= 16'd8) ? 8'hFF : 8'((9'd1 << rem[2:0]) - 9'd1);

   assign nb_w = 14'(({1'b0, q_w} + 17'd7) >> 3);

   always_comb begin
      mraddr_full = '0;
      chk_full    = '0;
      case (state_ff)
         S_B_RD: begin
            mraddr_full = {4'd0, bbyte};
            chk_full    = {4'd0, bbyte};
         end
         S_BR_RD0: begin
            mraddr_full = {4'd0, rb_lo};
            chk_full    = {4'd0, rb_lo};
         end
         S_BR_WAIT, S_BR_EMIT: begin
            mraddr_full = {4'd0, rb_hi};
            chk_full    = {4'd0, rb_hi};
         end
         S_RR_RDH, S_RR_EH: begin
            mraddr_full = ra1;
            chk_full    = ra1;
         end
         S_RR_RDL, S_RR_EL: begin
            mraddr_full = ra0;
            chk_full    = ra1;   // a register reads as zero unless both bytes exist
         end
         default: begin
            mraddr_full = '0;
            chk_full    = '0;
         end
      endcase
   end

   assign mem_raddr = mraddr_full[MAW-1:0];
   assign rd_ok_in  = in_ff && (chk_full < 18'(MEM_BYTES));

   always_comb begin
      case (state_ff)
         S_B_RD:  frm_raddr = DATA_POS + {1'b0, idx_ff[7:3]};
         S_R_RD0: frm_raddr = DATA_POS + {idx_ff[4:0], 1'b0};
         S_R_RD1: frm_raddr = DATA_POS2 + {idx_ff[4:0], 1'b0};
         default: frm_raddr = '0;
      endcase
   end

   assign bitval = (hdr_ff[1] == FC_WRITE_COIL) ? (hdr_ff[4] == COIL_ON) : frm_q[idx_ff[2:0]];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         S_B_WR: begin
            mem_we    = (bbyte < 14'(MEM_BYTES));
            mem_waddr = bbyte[MAW-1:0];
            mem_wdata = bitval ? (mem_rdata | bit_m) : (mem_rdata & ~bit_m);
         end
         S_R_WR0: begin
            mem_we    = (ra1 < 18'(MEM_BYTES));
            mem_waddr = ra0[MAW-1:0];
            mem_wdata = (hdr_ff[1] == FC_WRITE_REG) ? hdr_ff[5] : frm_q;
         end
         S_R_WR1: begin
            mem_we    = (ra1 < 18'(MEM_BYTES));
            mem_waddr = ra1[MAW-1:0];
            mem_wdata = (hdr_ff[1] == FC_WRITE_REG) ? hdr_ff[4] : hi_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_comb begin
      emit_req  = 1'b0;
      emit_last = 1'b0;
      emit_byte = '0;
      case (state_ff)
         S_HDR: begin
            emit_req = 1'b1;
            case (hidx_ff)
               3'd0:    emit_byte = slave_ff;
               3'd1:    emit_byte = hdr_ff[1];
               3'd2:    emit_byte = is_read ? cnt_byte : hdr_ff[2];
               3'd3:    emit_byte = hdr_ff[3];
               3'd4:    emit_byte = hdr_ff[4];
               default: emit_byte = hdr_ff[5];
            endcase
         end
         S_BR_EMIT: begin
            emit_req  = 1'b1;
            emit_byte = win[7:0] & bmask;
         end
         S_RR_EH, S_RR_EL: begin
            emit_req  = 1'b1;
            emit_byte = mem_q;
         end
         S_CRCL: begin
            emit_req  = 1'b1;
            emit_byte = crc_tx_ff[7:0];
         end
         S_CRCH: begin
            emit_req  = 1'b1;
            emit_byte = crc_tx_ff[15:8];
            emit_last = 1'b1;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   assign emit_fire = emit_req && o_free;

   // receive-side decisions for the byte on the input
   always_comb begin
      cnt_eff  = req_frame_start ? 7'd0 : cnt_ff;
      disc_eff = req_frame_start ? 1'b0 : disc_ff;
      cnt_n    = cnt_eff + 7'd1;
      b0       = (cnt_eff == 7'd0) ? req_rx_byte : hdr_ff[0];
      fcb      = (cnt_eff == 7'd1) ? req_rx_byte : hdr_ff[1];
      b6       = (cnt_eff == 7'd6) ? req_rx_byte : hdr_ff[6];
      frm_we   = 1'b0;
      frm_waddr = cnt_eff[STORE_AW-1:0];
      len      = FIXED_LEN;
      len_ok   = 1'b0;
      start    = 1'b0;
      cnt_in   = cnt_ff;
      disc_in  = disc_ff;
      if (req_fire) begin
         cnt_in  = cnt_eff;
         disc_in = disc_eff;
         if (!disc_eff) begin
            if (cnt_eff >= 7'(LIMIT)) begin
               disc_in = 1'b1;
            end else begin
               frm_we = 1'b1;
               cnt_in = cnt_n;
               if (b0 != slave_ff) begin
                  disc_in = 1'b1;
               end else if (cnt_n >= 7'd2) begin
                  if (fcb inside {[FC_READ_COILS:FC_WRITE_REG]}) begin
                     len_ok = 1'b1;
                  end else if (fcb inside {FC_WRITE_COILS, FC_WRITE_REGS}) begin
                     if (cnt_n >= COUNT_POS_N) begin
                        if (b6 > MAX_DATA) begin
                           disc_in = 1'b1;
                        end else begin
                           len_ok = 1'b1;
                           len    = b6[6:0] + MULTI_EXTRA;
                        end
                     end
                  end else begin
                     disc_in = 1'b1;
                  end
                  if (len_ok) begin
                     if (len > 7'(LIMIT)) begin
                        disc_in = 1'b1;
                     end else if (cnt_n >= len) begin
                        cnt_in = 7'd0;
                        start  = (crc_d1_ff == {req_rx_byte, prev_ff});
                     end
                  end
               end
            end
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      hdr_in         = hdr_ff;
      prev_in        = prev_ff;
      crc_run_in     = crc_run_ff;
      crc_d1_in      = crc_d1_ff;
      crc_tx_in      = crc_tx_ff;
      in_in          = in_ff;
      rel_in         = rel_ff;
      idx_in         = idx_ff;
      ncount_in      = ncount_ff;
      hidx_in        = hidx_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      clr_in         = clr_ff;
      slave_in       = slave_ff;
      base_in        = base_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_tx_byte_in = rsp_tx_byte_ff;
      rsp_last_in    = rsp_last_ff;
      cap16          = '0;
      n16            = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_SLAVE_ADDRESS: slave_in = csr_wr_data[7:0];
            CSR_AREA_BASE:     base_in  = csr_wr_data;
            default:           slave_in = slave_ff;
         endcase
      end

      if (emit_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_tx_byte_in = emit_byte;
         rsp_last_in    = emit_last;
         if (state_ff != S_CRCL && state_ff != S_CRCH) begin
            crc_tx_in = crc16_byte(crc_tx_ff, emit_byte);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (frm_we) begin
         prev_in    = req_rx_byte;
         crc_d1_in  = (cnt_eff == 7'd0) ? CRC_INIT : crc_run_ff;
         crc_run_in = crc16_byte(crc_d1_in, req_rx_byte);
         if (cnt_eff < 7'd7) begin
            hdr_in[cnt_eff[2:0]] = req_rx_byte;
         end
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == MAW'(MEM_BYTES - 1)) begin
               state_in = S_RX;
            end
         end
         S_RX: begin
            if (start) begin
               in_in     = in_c;
               rel_in    = rel_c;
               idx_in    = '0;
               hidx_in   = '0;
               crc_tx_in = CRC_INIT;
               case (hdr_ff[1])
                  FC_READ_COILS, FC_READ_DISCRETE: begin
                     ncount_in = nb_w[8:0];
                     if (nb_w <= 14'(MAX_DATA)) begin
                        state_in = S_HDR;
                     end
                  end
                  FC_READ_HOLDING, FC_READ_INPUT: begin
                     ncount_in = q_w[8:0];
                     if (q_w <= 16'(MAX_REGS)) begin
                        state_in = S_HDR;
                     end
                  end
                  FC_WRITE_COIL: begin
                     if (in_c && hdr_ff[5] == 8'd0 &&
                         (hdr_ff[4] == COIL_ON || hdr_ff[4] == 8'd0)) begin
                        ncount_in = 9'd1;
                        state_in  = S_B_RD;
                     end else begin
                        state_in = S_HDR;
                     end
                  end
                  FC_WRITE_REG: begin
                     ncount_in = 9'd1;
                     state_in  = in_c ? S_R_RD0 : S_HDR;
                  end
                  FC_WRITE_COILS: begin
                     cap16     = {5'd0, hdr_ff[6], 3'd0};
                     n16       = (q_w < cap16) ? q_w : cap16;
                     ncount_in = n16[8:0];
                     state_in  = (in_c && n16 != 16'd0) ? S_B_RD : S_HDR;
                  end
                  default: begin
                     cap16     = {9'd0, hdr_ff[6][7:1]};
                     n16       = (q_w < cap16) ? q_w : cap16;
                     ncount_in = n16[8:0];
                     state_in  = (in_c && n16 != 16'd0) ? S_R_RD0 : S_HDR;
                  end
               endcase
            end
         end
         S_B_RD: state_in = S_B_WR;
         S_B_WR: begin
            idx_in   = idx_ff + 9'd1;
            state_in = loop_done ? S_HDR : S_B_RD;
         end
         S_R_RD0: state_in = S_R_RD1;
         S_R_RD1: begin
            hi_in    = frm_q;
            state_in = S_R_WR0;
         end
         S_R_WR0: state_in = S_R_WR1;
         S_R_WR1: begin
            idx_in   = idx_ff + 9'd1;
            state_in = loop_done ? S_HDR : S_R_RD0;
         end
         S_HDR: begin
            if (emit_fire) begin
               hidx_in = hidx_ff + 3'd1;
               if (last_hdr) begin
                  idx_in = '0;
                  if (!is_read || ncount_ff == 9'd0) begin
                     state_in = S_CRCL;
                  end else begin
                     state_in = is_bits ? S_BR_RD0 : S_RR_RDH;
                  end
               end
            end
         end
         S_BR_RD0: state_in = S_BR_LO;
         S_BR_LO: begin
            lo_in    = mem_q;
            state_in = S_BR_WAIT;
         end
         S_BR_WAIT: state_in = S_BR_EMIT;
         S_BR_EMIT: begin
            if (emit_fire) begin
               lo_in    = mem_q;
               idx_in   = idx_ff + 9'd1;
               state_in = loop_done ? S_CRCL : S_BR_WAIT;
            end
         end
         S_RR_RDH: state_in = S_RR_EH;
         S_RR_EH: begin
            if (emit_fire) begin
               state_in = S_RR_RDL;
            end
         end
         S_RR_RDL: state_in = S_RR_EL;
         S_RR_EL: begin
            if (emit_fire) begin
               idx_in   = idx_ff + 9'd1;
               state_in = loop_done ? S_CRCL : S_RR_RDH;
            end
         end
         S_CRCL: begin
            if (emit_fire) begin
               state_in = S_CRCH;
            end
         end
         S_CRCH: begin
            if (emit_fire) begin
               state_in = S_RX;
            end
         end
         default: state_in = S_RX;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         disc_ff      <= 1'b0;
         clr_ff       <= '0;
         slave_ff     <= SLAVE_ADDRESS_RESET;
         base_ff      <= AREA_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         disc_ff      <= disc_in;
         clr_ff       <= clr_in;
         slave_ff     <= slave_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hdr_ff         <= hdr_in;
      prev_ff        <= prev_in;
      crc_run_ff     <= crc_run_in;
      crc_d1_ff      <= crc_d1_in;
      crc_tx_ff      <= crc_tx_in;
      in_ff          <= in_in;
      rel_ff         <= rel_in;
      idx_ff         <= idx_in;
      ncount_ff      <= ncount_in;
      hidx_ff        <= hidx_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      rd_ok_ff       <= rd_ok_in;
      rsp_tx_byte_ff <= rsp_tx_byte_in;
      rsp_last_ff    <= rsp_last_in;
   end

   `MBSLV_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= 7'(LIMIT))
   `MBSLV_ASSERT_IMP(a_we_state, mem_we, state_ff == S_CLEAR || state_ff == S_B_WR || state_ff == S_R_WR0 || state_ff == S_R_WR1)
   `MBSLV_ASSERT_IMP(a_serve_fc, state_ff != S_RX && state_ff != S_CLEAR, is_read || hdr_ff[1] == FC_WRITE_COIL || hdr_ff[1] == FC_WRITE_REG || hdr_ff[1] == FC_WRITE_COILS || hdr_ff[1] == FC_WRITE_REGS)
   `MBSLV_ASSERT_NXT(a_crc_end, state_ff == S_CRCH && o_free, state_ff == S_RX && rsp_last_ff)

endmodule

### rtl/mbslv_ram.sv
module mbslv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/mbslv_scoreboard.sv
`timescale 1ns / 1ps

module mbslv_scoreboard
   import mbslv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_frame_start,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_tx_byte,
   input  logic                  rsp_last,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    errors,
   output int                    pending
);

   localparam int MEM_SIZE = 64;
   localparam int FRAME_MAX = 64;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } reply_byte_t;

   reply_byte_t reply_q[$];

   logic [7:0]  rx_frame [FRAME_MAX];
   logic [7:0]  coil_mem [MEM_SIZE];
   int unsigned rx_count;
   bit          dropping;
   logic [7:0]  station;
   logic [15:0] base_addr;

   initial errors = 0;
   assign pending = reply_q.size();

   function automatic logic [15:0] modbus_crc(input logic [7:0] d[$]);
      logic [15:0] r;
      r = 16'hFFFF;
      foreach (d[i]) begin
         r ^= {8'd0, d[i]};
         for (int j = 0; j < 8; j++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   task automatic report(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic report_leftover();
      while (reply_q.size() != 0) begin
         report($sformatf("expected byte %02h never sent", reply_q[0].tx_byte));
         void'(reply_q.pop_front());
      end
   endtask

   function automatic bit coil_rd(input int unsigned k);
      if ((k >> 3) >= MEM_SIZE) return 1'b0;
      return coil_mem[k >> 3][k & 7];
   endfunction

   function automatic void coil_wr(input int unsigned k, input bit v);
      if ((k >> 3) >= MEM_SIZE) return;
      coil_mem[k >> 3][k & 7] = v;
   endfunction

   function automatic logic [15:0] reg_rd(input int unsigned r);
      if (2 * r + 1 >= MEM_SIZE) return 16'd0;
      return {coil_mem[2 * r + 1], coil_mem[2 * r]};
   endfunction

   function automatic void reg_wr(input int unsigned r, input logic [7:0] hi, input logic [7:0] lo);
      if (2 * r + 1 >= MEM_SIZE) return;
      coil_mem[2 * r]     = lo;
      coil_mem[2 * r + 1] = hi;
   endfunction

   // run a checked request on the memory; empty reply means dropped
   task automatic serve_request(output logic [7:0] tx[$]);
      int unsigned addr, qty, rel, n, v;
      bit          in_area;
      logic [7:0]  fc;
      tx = {};
      fc = rx_frame[1];
      addr = {rx_frame[2], rx_frame[3]};
      qty = {rx_frame[4], rx_frame[5]};
      in_area = addr >= base_addr;
      rel = addr - base_addr;
      tx.push_back(station);
      tx.push_back(fc);
      if (fc == FC_READ_COILS || fc == FC_READ_DISCRETE) begin
         n = (qty + 7) >> 3;
         if (n > MAX_DATA) begin
            tx = {};
            return;
         end
         tx.push_back(n[7:0]);
         for (int unsigned i = 0; i < n; i++) begin
            v = 0;
            for (int unsigned k = 0; k < 8; k++)
               if (in_area && 8 * i + k < qty) v |= coil_rd(rel + 8 * i + k) << k;
            tx.push_back(v[7:0]);
         end
         return;
      end
      if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
         if (qty > MAX_REGS) begin
            tx = {};
            return;
         end
         tx.push_back(8'(2 * qty));
         for (int unsigned i = 0; i < qty; i++) begin
            v = in_area ? reg_rd(rel + i) : 0;
            tx.push_back(v[15:8]);
            tx.push_back(v[7:0]);
         end
         return;
      end
      if (fc == FC_WRITE_COIL) begin
         if (in_area && rx_frame[5] == 8'd0) begin
            if (rx_frame[4] == COIL_ON) coil_wr(rel, 1'b1);
            else if (rx_frame[4] == 8'd0) coil_wr(rel, 1'b0);
         end
      end else if (fc == FC_WRITE_REG) begin
         if (in_area) reg_wr(rel, rx_frame[4], rx_frame[5]);
      end else if (fc == FC_WRITE_COILS) begin
         n = 8 * rx_frame[6];
         if (qty < n) n = qty;
         if (in_area)
            for (int unsigned i = 0; i < n; i++)
               coil_wr(rel + i, rx_frame[7 + (i >> 3)][i & 7]);
      end else begin
         n = rx_frame[6] >> 1;
         if (qty < n) n = qty;
         if (in_area)
            for (int unsigned i = 0; i < n; i++)
               reg_wr(rel + i, rx_frame[7 + 2 * i], rx_frame[8 + 2 * i]);
      end
      for (int i = 2; i < 6; i++) tx.push_back(rx_frame[i]);
   endtask

   task automatic take_rx_byte(input logic [7:0] b, input logic fs);
      logic [7:0]  fc;
      int unsigned flen;
      logic [7:0]  body[$];
      logic [7:0]  tx[$];
      logic [15:0] crc;
      if (fs) begin
         rx_count = 0;
         dropping = 1'b0;
      end
      if (dropping) return;
      if (rx_count >= FRAME_MAX) begin
         dropping = 1'b1;
         return;
      end
      rx_frame[rx_count] = b;
      rx_count++;
      if (rx_frame[0] != station) begin
         dropping = 1'b1;
         return;
      end
      if (rx_count < 2) return;
      fc = rx_frame[1];
      if (fc >= FC_READ_COILS && fc <= FC_WRITE_REG) begin
         flen = FIXED_LEN;
      end else if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
         if (rx_count < COUNT_POS_N) return;
         if (rx_frame[6] > MAX_DATA) begin
            dropping = 1'b1;
            return;
         end
         flen = rx_frame[6] + MULTI_EXTRA;
      end else begin
         dropping = 1'b1;
         return;
      end
      if (rx_count < flen) return;
      rx_count = 0;
      for (int unsigned i = 0; i < flen - 2; i++) body.push_back(rx_frame[i]);
      if (modbus_crc(body) != {rx_frame[flen - 1], rx_frame[flen - 2]}) return;
      serve_request(tx);
      if (tx.size() == 0) return;
      crc = modbus_crc(tx);
      tx.push_back(crc[7:0]);
      tx.push_back(crc[15:8]);
      foreach (tx[i]) reply_q.push_back('{tx[i], i == tx.size() - 1});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reply_q.delete();
         foreach (coil_mem[i]) coil_mem[i] = 8'd0;
         rx_count = 0;
         dropping = 1'b0;
         station = SLAVE_ADDRESS_RESET;
         base_addr = AREA_BASE_RESET;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               report($sformatf("unexpected byte %02h", rsp_tx_byte));
            end else begin
               if (rsp_tx_byte !== reply_q[0].tx_byte)
                  report($sformatf("tx_byte %02h, expected %02h", rsp_tx_byte,
                                   reply_q[0].tx_byte));
               if (rsp_last !== reply_q[0].last)
                  report($sformatf("last %b, expected %b", rsp_last, reply_q[0].last));
               void'(reply_q.pop_front());
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_SLAVE_ADDRESS) station = csr_wr_data[7:0];
            else if (csr_index == CSR_AREA_BASE) base_addr = csr_wr_data;
         end
         if (req_valid && req_ready) take_rx_byte(req_rx_byte, req_frame_start);
      end
   end

endmodule

### verif/tb_modbus_rtu_slave_bit_register_memory_unit.sv
`timescale 1ns / 1ps

module tb_modbus_rtu_slave_bit_register_memory_unit;
   import mbslv_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  req_frame_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_last;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_SLAVE_ADDRESS;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int          errors;
   int          pending;
   int          burst_left = 0;
   bit          no_gaps = 1'b0;
   int          stall_mode = 0;
   int          bytes_sent = 0;
   logic [7:0]  cur_station = SLAVE_ADDRESS_RESET;
   logic [15:0] cur_base = AREA_BASE_RESET;

   modbus_rtu_slave_bit_register_memory_unit u_dut (
      .clock, .reset, .req_valid, .req_ready, .req_rx_byte, .req_frame_start,
      .rsp_valid, .rsp_ready, .rsp_tx_byte, .rsp_last, .csr_wr_en, .csr_index, .csr_wr_data
   );

   mbslv_scoreboard u_chk (
      .clock, .reset, .req_valid, .req_ready, .req_rx_byte, .req_frame_start,
      .rsp_valid, .rsp_ready, .rsp_tx_byte, .rsp_last, .csr_wr_en, .csr_index, .csr_wr_data,
      .errors, .pending
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("tb_modbus_rtu_slave_bit_register_memory_unit: FAIL");
      $finish;
   end

   // receiver: stall mode changes every so often
   always @(posedge clock) begin
      if ($urandom_range(0, 150) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send_byte(input logic [7:0] b, input logic fs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         no_gaps = ($urandom_range(0, 3) == 0);
         gap = no_gaps ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] d[$], input logic fs);
      foreach (d[i]) send_byte(d[i], (i == 0) ? fs : 1'b0);
   endtask

   // builds one request; payload bytes only for the multi-write codes
   task automatic send_request(input logic [7:0] sa, input logic [7:0] fc,
                               input logic [15:0] addr, input logic [15:0] qty,
                               input int byte_cnt, input bit bad_crc, input logic fs);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      frame = {sa, fc, addr[15:8], addr[7:0], qty[15:8], qty[7:0]};
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS) begin
         frame.push_back(byte_cnt[7:0]);
         repeat (byte_cnt) frame.push_back($urandom_range(0, 255));
      end
      crc = u_chk.modbus_crc(frame);
      if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      send_bytes(frame, fs);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] sa, input logic [15:0] base);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SLAVE_ADDRESS;
      csr_wr_data <= {8'd0, sa};
      @(posedge clock);
      csr_index <= CSR_AREA_BASE;
      csr_wr_data <= base;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_station = sa;
      cur_base = base;
   endtask

   task automatic random_request();
      logic [7:0]  sa, fc;
      logic [15:0] addr, qty;
      int          bc, sel;
      logic [7:0]  junk[$];
      sa = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cur_station;
      sel = $urandom_range(0, 17);
      case (sel)
         0, 1: fc = FC_READ_COILS;
         2: fc = FC_READ_DISCRETE;
         3, 4: fc = FC_READ_HOLDING;
         5: fc = FC_READ_INPUT;
         6, 7: fc = FC_WRITE_COIL;
         8, 9: fc = FC_WRITE_REG;
         10, 11, 12: fc = FC_WRITE_COILS;
         13, 14, 15: fc = FC_WRITE_REGS;
         default: fc = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 9))
         0: addr = $urandom_range(0, 65535);
         1: addr = cur_base - 16'($urandom_range(1, 40));
         default: addr = cur_base + 16'($urandom_range(0, 540));
      endcase
      bc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 33) : $urandom_range(0, 8);
      case (fc)
         FC_READ_COILS, FC_READ_DISCRETE:
            qty = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 260);
         FC_READ_HOLDING, FC_READ_INPUT:
            qty = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 18);
         FC_WRITE_COIL:
            case ($urandom_range(0, 2))
               0: qty = 16'hFF00;
               1: qty = 16'h0000;
               default: qty = $urandom_range(0, 65535);
            endcase
         FC_WRITE_COILS: qty = $urandom_range(0, 8 * bc + 4);
         FC_WRITE_REGS: qty = $urandom_range(0, bc / 2 + 2);
         default: qty = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 19))
         0: begin
            // cut-off frame, opened with a frame start; the next request does not always mark one
            repeat ($urandom_range(1, 7)) junk.push_back($urandom_range(0, 255));
            junk[0] = sa;
            send_bytes(junk, 1'b1);
         end
         1: begin
            repeat ($urandom_range(1, 6)) junk.push_back($urandom_range(0, 255));
            foreach (junk[i]) send_byte(junk[i], $urandom_range(0, 1));
         end
         default:
            send_request(sa, fc, addr, qty, bc, $urandom_range(0, 9) == 0,
                         $urandom_range(0, 6) != 0);
      endcase
   endtask

   task automatic directed_set();
      logic [15:0] b;
      b = cur_base;
      send_request(cur_station, FC_WRITE_REGS, b, 16'd16, 32, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_HOLDING, b, 16'd16, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_INPUT, b + 16'd31, 16'd2, 0, 1'b0, 1'b0);
      send_request(cur_station, FC_READ_HOLDING, b, 16'd17, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_COILS, b, 16'd256, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_DISCRETE, b + 16'd500, 16'd20, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_COILS, b, 16'd257, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_COILS, b, 16'd0, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_COIL, b + 16'd3, 16'hFF00, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_COIL, b + 16'd4, 16'h0000, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_COIL, b + 16'd5, 16'h1234, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_REG, b + 16'd2, 16'hA55A, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_COILS, b + 16'd7, 16'd300, 32, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_COILS, b + 16'd1, 16'd5, 2, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_REGS, b + 16'd1, 16'd1, 6, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_REGS, b, 16'd2, 33, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_COILS, b, 16'd64, 0, 1'b1, 1'b1);
      send_request(cur_station + 8'd1, FC_READ_COILS, b, 16'd8, 0, 1'b0, 1'b1);
      send_request(cur_station, 8'd7, b, 16'd8, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_HOLDING, b - 16'd1, 16'd4, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_WRITE_REG, b - 16'd1, 16'h5555, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_COILS, 16'hFFFF, 16'd16, 0, 1'b0, 1'b1);
      send_request(cur_station, FC_READ_HOLDING, b, 16'd16, 0, 1'b0, 1'b1);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_set();
      drain();
      set_config(8'd247, 16'd0);
      directed_set();
      repeat (6) random_request();
      drain();
      set_config(8'd1, 16'hFFFF);
      directed_set();
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         set_config($urandom_range(1, 247), (ph == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
         begin
            int goal;
            goal = bytes_sent + 120;
            while (bytes_sent < goal) random_request();
         end
         drain();
      end
      u_chk.report_leftover();
      if (errors == 0) begin
         $display("tb_modbus_rtu_slave_bit_register_memory_unit: PASS");
      end else begin
         $display("tb_modbus_rtu_slave_bit_register_memory_unit: FAIL");
      end
      $finish;
   end

endmodule

### modbus_rtu_slave_bit_register_memory_unit.f
+incdir+rtl
rtl/mbslv_pkg.sv
rtl/mbslv_ram.sv
rtl/modbus_rtu_slave_bit_register_memory_unit.sv
verif/mbslv_scoreboard.sv
verif/tb_modbus_rtu_slave_bit_register_memory_unit.sv
